// ===== sv/ufdb_pkg.sv =====
// Package for the UART frame double-buffer receiver.
// Holds the request and result codes and the frame delimiter characters.
// No dependencies.
package ufdb_pkg;

	// request codes
	localparam logic [1:0] FN_BYTE = 2'd0;
	localparam logic [1:0] FN_IDLE = 2'd1;
	localparam logic [1:0] FN_READ = 2'd2;

	// result status codes
	localparam logic [2:0] ST_EMPTY    = 3'd0;
	localparam logic [2:0] ST_PARTIAL  = 3'd1;
	localparam logic [2:0] ST_FRAME    = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_FORCED   = 3'd4;
	localparam logic [2:0] ST_READ     = 3'd5;

	// 7-bit control characters, parity stripped
	localparam logic [6:0] CH_STX = 7'h02;
	localparam logic [6:0] CH_ETX = 7'h03;
	localparam logic [6:0] CH_ENQ = 7'h05;
	localparam logic [6:0] CH_ACK = 7'h06;
	localparam logic [6:0] CH_NAK = 7'h15;

	// shortest STX frame, and ETX position counted from the end
	localparam int MIN_STX_LEN = 4;
	localparam int ETX_FROM_END = 3;

endpackage

// ===== sv/ufdb_if.sv =====
// Request and result channel interfaces for the UART frame receiver.
// Valid/ready handshake; a request moves when both are high at a clock edge.
// Uses no package.
interface ufdb_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  rx_byte;
	logic        force_reset;
	logic [31:0] tick_value;
	logic        read_buffer;
	logic [8:0]  read_index;

	modport source (
		output valid, func, rx_byte, force_reset, tick_value, read_buffer, read_index,
		input  ready
	);
	modport sink (
		input  valid, func, rx_byte, force_reset, tick_value, read_buffer, read_index,
		output ready
	);
endinterface

interface ufdb_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        frame_buffer;
	logic [9:0]  frame_length;
	logic        partial_active;
	logic [31:0] partial_tick;
	logic [7:0]  read_data;

	modport source (
		output valid, status, frame_buffer, frame_length, partial_active, partial_tick,
		       read_data,
		input  ready
	);
	modport sink (
		input  valid, status, frame_buffer, frame_length, partial_active, partial_tick,
		       read_data,
		output ready
	);
endinterface

// ===== sv/ufdb_store.sv =====
// Two-half byte store of the UART frame receiver.
// One write port, one read port with registered read data.
// Uses no package.
module ufdb_store #(
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read, so a stalled consumer keeps it
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/uart_frame_double_buffer_receiver_top.sv =====
// Top level of the UART idle-line frame receiver with a double-buffered store.
// Depends on ufdb_pkg, ufdb_if (channels) and ufdb_store.
//
// Usage:
//   cmd carries one request per handshake: a received byte, a line-idle event
//   or a read of a stored byte. result returns one item for each idle event
//   and each read; byte requests give none.
//   A byte goes straight into the active half of the store (dropped when the
//   half is full). An idle event reads the byte third from the end and, with
//   the first byte kept in a register, decides: frame delivered (halves swap),
//   partial kept (tick stamped), overflow or forced discard (halves swap), or empty.
// Throughput: bytes and reads are taken one per cycle unless a waiting result
//   holds stage 1. An idle event holds off the next request until it retires
//   from stage 1, since its verdict needs the store read and changes the fill
//   state before the next request may look at it.
// Stall: the result register and a one-deep stage in front of it let one
//   more idle or read request enter while a result waits (bytes keep flowing
//   until then); beyond that cmd.ready drops.
// Reset: fill count, active half, partial flag and stamp clear at once; the
//   store contents stay undefined until written, with no clearing pass.
module uart_frame_double_buffer_receiver_top
	import ufdb_pkg::*;
#(
	parameter int BUF_DEPTH = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	ufdb_cmd_if.sink      cmd,
	ufdb_result_if.source result
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int FW = $clog2(BUF_DEPTH + 1);

	// fill state
	logic          active_q;
	logic [FW-1:0] fill_q;
	logic [6:0]    first_q;
	logic          partial_q;
	logic [31:0]   stamp_q;

	// stage 1: request waiting on store read data
	logic        valid_s1;
	logic        idle_s1;
	logic        force_s1;
	logic        in_range_s1;
	logic [31:0] tick_s1;

	// result register
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic        fbuf_q;
	logic [9:0]  flen_q;
	logic        pact_q;
	logic [31:0] ptick_q;
	logic [7:0]  rdata_q;

	logic          accept;
	logic          advance;
	logic          fill_full;
	logic          wr_en;
	logic          rd_en;
	logic [AW:0]   rd_addr;
	logic [AW-1:0] tail_idx;
	logic          in_range;
	logic [7:0]    rd_data;
	logic          first_single;
	logic          complete;
	logic [2:0]    nxt_status;
	logic          nxt_partial;
	logic [31:0]   nxt_stamp;
	logic          nxt_swap;

	assign advance   = valid_s1 && (!out_valid_q || result.ready);
	// an idle event in stage 1 owns the fill state until it retires
	assign cmd.ready = !valid_s1 || (advance && !idle_s1);
	assign accept    = cmd.valid && cmd.ready;

	assign fill_full = (fill_q == FW'(BUF_DEPTH));
	assign wr_en     = accept && (cmd.func == FN_BYTE) && !fill_full;
	assign rd_en     = accept && (cmd.func == FN_IDLE || cmd.func == FN_READ);
	assign tail_idx  = AW'(fill_q - FW'(ETX_FROM_END));
	assign in_range  = 32'(cmd.read_index) < 32'(BUF_DEPTH);
	assign rd_addr   = (cmd.func == FN_IDLE) ? {active_q, tail_idx}
	                                         : {cmd.read_buffer, AW'(cmd.read_index)};

	ufdb_store #(
		.ADDR_W(AW + 1)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr({active_q, AW'(fill_q)}),
		.wr_data(cmd.rx_byte),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign first_single = (first_q == CH_ACK) || (first_q == CH_NAK) || (first_q == CH_ENQ);
	assign complete = ((fill_q == FW'(1)) && first_single)
		|| ((fill_q >= FW'(MIN_STX_LEN)) && (first_q == CH_STX) && (rd_data[6:0] == CH_ETX));

	// idle-event verdict
	always_comb begin
		nxt_status  = ST_EMPTY;
		nxt_partial = partial_q;
		nxt_stamp   = stamp_q;
		nxt_swap    = 1'b0;
		priority if (force_s1) begin
			nxt_status  = ST_FORCED;
			nxt_partial = 1'b0;
			nxt_swap    = 1'b1;
		end else if (fill_full) begin
			nxt_status  = ST_OVERFLOW;
			nxt_partial = 1'b0;
			nxt_swap    = 1'b1;
		end else if (complete) begin
			nxt_status  = ST_FRAME;
			nxt_partial = 1'b0;
			nxt_swap    = 1'b1;
		end else if (fill_q != '0) begin
			nxt_status  = ST_PARTIAL;
			nxt_partial = 1'b1;
			nxt_stamp   = tick_s1;
		end else begin
			nxt_status  = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			fill_q    <= '0;
			partial_q <= 1'b0;
			stamp_q   <= '0;
		end else begin
			if (advance && idle_s1) begin
				partial_q <= nxt_partial;
				stamp_q   <= nxt_stamp;
				if (nxt_swap) begin
					active_q <= !active_q;
					fill_q   <= '0;
				end
			end else if (wr_en) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && fill_q == '0) begin
			first_q <= cmd.rx_byte[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_en) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idle_s1     <= (cmd.func == FN_IDLE);
			force_s1    <= cmd.force_reset;
			in_range_s1 <= in_range;
			tick_s1     <= cmd.tick_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (idle_s1) begin
				status_q <= nxt_status;
				fbuf_q   <= (nxt_status == ST_FRAME) ? active_q : 1'b0;
				flen_q   <= (nxt_status == ST_FRAME) ? 10'(fill_q) : 10'd0;
				pact_q   <= nxt_partial;
				ptick_q  <= nxt_stamp;
				rdata_q  <= 8'd0;
			end else begin
				status_q <= ST_READ;
				fbuf_q   <= 1'b0;
				flen_q   <= 10'd0;
				pact_q   <= partial_q;
				ptick_q  <= stamp_q;
				rdata_q  <= in_range_s1 ? rd_data : 8'd0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = status_q;
	assign result.frame_buffer   = fbuf_q;
	assign result.frame_length   = flen_q;
	assign result.partial_active = pact_q;
	assign result.partial_tick   = ptick_q;
	assign result.read_data      = rdata_q;

endmodule

// ===== sim/uart_frame_double_buffer_receiver_top_tb.sv =====
// Self-checking testbench for the UART idle-line frame receiver (double-buffered store).
// Depends on ufdb_pkg, ufdb_if and uart_frame_double_buffer_receiver_top; drives cmd requests,
// predicts each result in lockstep and compares every field of every result.
module uart_frame_double_buffer_receiver_top_tb;
	import ufdb_pkg::*;

	localparam int BUF_DEPTH = 512;
	localparam int CLK_PERIOD = 12;
	localparam int LIMIT_CYCLES = 400000;
	// request code the block ignores
	localparam logic [1:0] FN_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  rx_byte;
		logic        force_reset;
		logic [31:0] tick_value;
		logic        read_buffer;
		logic [8:0]  read_index;
	} rx_req_t;

	localparam int REQ_W = $bits(rx_req_t);

	typedef struct packed {
		logic [2:0]  status;
		logic        frame_buffer;
		logic [9:0]  frame_length;
		logic        partial_active;
		logic [31:0] partial_tick;
		logic [7:0]  read_data;
	} rx_outcome_t;

	logic clk;
	logic arst_n;

	ufdb_cmd_if    cmd_ch();
	ufdb_result_if res_ch();

	uart_frame_double_buffer_receiver_top #(
		.BUF_DEPTH(BUF_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.result(res_ch)
	);

	// shadow of the receiver state
	logic [7:0]  rx_image [2][BUF_DEPTH];
	int          written_upto [2];
	logic        shadow_half;
	int          shadow_fill;
	logic        shadow_partial;
	logic [31:0] shadow_stamp;

	rx_outcome_t awaited_outcomes [$];
	int          mismatches;
	int          reqs_sent;
	int          results_seen;
	int          src_gap_pct;
	int          snk_stall_pct;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout: %0d results still awaited", awaited_outcomes.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 40) begin
			$display("mismatch at result %0d (t=%0t): %s", results_seen, $realtime, msg);
		end
		mismatches++;
	endtask

	function automatic bit holds_complete_frame(input logic h, input int len);
		logic [6:0] first;
		if (len == 0)
			return 1'b0;
		first = rx_image[h][0][6:0];
		if (len == 1)
			return first == CH_ACK || first == CH_NAK || first == CH_ENQ;
		return len >= MIN_STX_LEN && first == CH_STX &&
			rx_image[h][len - ETX_FROM_END][6:0] == CH_ETX;
	endfunction

	function automatic void advance_rx_state(input rx_req_t r, output rx_outcome_t o,
			output bit has);
		o = '0;
		has = 1'b0;
		case (r.func)
			FN_BYTE: begin
				// bytes into a full half are dropped
				if (shadow_fill < BUF_DEPTH) begin
					rx_image[shadow_half][shadow_fill] = r.rx_byte;
					shadow_fill++;
					if (shadow_fill > written_upto[shadow_half])
						written_upto[shadow_half] = shadow_fill;
				end
			end
			FN_IDLE: begin
				has = 1'b1;
				if (r.force_reset) begin
					shadow_partial = 1'b0;
					shadow_half = ~shadow_half;
					shadow_fill = 0;
					o.status = ST_FORCED;
				end else if (shadow_fill >= BUF_DEPTH) begin
					shadow_partial = 1'b0;
					shadow_half = ~shadow_half;
					shadow_fill = 0;
					o.status = ST_OVERFLOW;
				end else if (holds_complete_frame(shadow_half, shadow_fill)) begin
					shadow_partial = 1'b0;
					o.frame_buffer = shadow_half;
					o.frame_length = 10'(shadow_fill);
					shadow_half = ~shadow_half;
					shadow_fill = 0;
					o.status = ST_FRAME;
				end else if (shadow_fill > 0) begin
					shadow_partial = 1'b1;
					shadow_stamp = r.tick_value;
					o.status = ST_PARTIAL;
				end else begin
					o.status = ST_EMPTY;
				end
			end
			FN_READ: begin
				has = 1'b1;
				o.status = ST_READ;
				if (r.read_index < BUF_DEPTH)
					o.read_data = rx_image[r.read_buffer][r.read_index];
			end
			default: ;
		endcase
		o.partial_active = shadow_partial;
		o.partial_tick = shadow_stamp;
	endfunction

	task automatic set_idling(input int src_pct, input int snk_pct);
		src_gap_pct = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	task automatic send_req(input rx_req_t r);
		rx_outcome_t o;
		bit has;
		int gap;
		if ($urandom_range(99) < src_gap_pct) begin
			cmd_ch.valid <= 1'b0;
			gap = ($urandom_range(7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 2);
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= r.func;
		cmd_ch.rx_byte <= r.rx_byte;
		cmd_ch.force_reset <= r.force_reset;
		cmd_ch.tick_value <= r.tick_value;
		cmd_ch.read_buffer <= r.read_buffer;
		cmd_ch.read_index <= r.read_index;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		advance_rx_state(r, o, has);
		if (has)
			awaited_outcomes.push_back(o);
		if (r.func != FN_UNUSED)
			reqs_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		rx_req_t r;
		r = REQ_W'({$urandom(), $urandom()});
		r.func = FN_BYTE;
		r.rx_byte = b;
		send_req(r);
	endtask

	task automatic send_idle(input logic force_rst, input logic [31:0] tick);
		rx_req_t r;
		r = REQ_W'({$urandom(), $urandom()});
		r.func = FN_IDLE;
		r.force_reset = force_rst;
		r.tick_value = tick;
		send_req(r);
	endtask

	task automatic send_read(input logic h, input logic [8:0] idx);
		rx_req_t r;
		r = REQ_W'({$urandom(), $urandom()});
		r.func = FN_READ;
		r.read_buffer = h;
		r.read_index = idx;
		send_req(r);
	endtask

	task automatic send_unused();
		rx_req_t r;
		r = REQ_W'({$urandom(), $urandom()});
		r.func = FN_UNUSED;
		send_req(r);
	endtask

	// reads only touch entries written since reset
	task automatic send_read_of_written();
		logic h;
		h = 1'($urandom_range(1));
		if (written_upto[h] == 0)
			h = ~h;
		if (written_upto[h] != 0)
			send_read(h, 9'($urandom_range(written_upto[h] - 1)));
	endtask

	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited_outcomes.size() != 0) @(posedge clk);
	endtask

	// result monitor and sink-side stall generator
	initial begin
		rx_outcome_t got;
		rx_outcome_t want;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.status = res_ch.status;
				got.frame_buffer = res_ch.frame_buffer;
				got.frame_length = res_ch.frame_length;
				got.partial_active = res_ch.partial_active;
				got.partial_tick = res_ch.partial_tick;
				got.read_data = res_ch.read_data;
				results_seen++;
				if (awaited_outcomes.size() == 0) begin
					report_mismatch($sformatf("unexpected result, status %0d", got.status));
				end else begin
					want = awaited_outcomes.pop_front();
					if (got.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							got.status, want.status));
					if (got.frame_buffer !== want.frame_buffer)
						report_mismatch($sformatf("frame_buffer %0d, want %0d",
							got.frame_buffer, want.frame_buffer));
					if (got.frame_length !== want.frame_length)
						report_mismatch($sformatf("frame_length %0d, want %0d",
							got.frame_length, want.frame_length));
					if (got.partial_active !== want.partial_active)
						report_mismatch($sformatf("partial_active %0d, want %0d",
							got.partial_active, want.partial_active));
					if (got.partial_tick !== want.partial_tick)
						report_mismatch($sformatf("partial_tick %h, want %h",
							got.partial_tick, want.partial_tick));
					if (got.read_data !== want.read_data)
						report_mismatch($sformatf("read_data %h, want %h",
							got.read_data, want.read_data));
				end
			end
			res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic test_directed_frames();
		send_idle(1'b0, 32'h1234_5678);     // nothing stored
		send_unused();
		send_byte({1'b0, CH_ACK});
		send_idle(1'b0, $urandom());
		send_byte({1'b1, CH_NAK});
		send_idle(1'b0, $urandom());
		send_byte({1'b0, CH_ENQ});
		send_idle(1'b0, $urandom());
		send_byte(8'h41);
		send_idle(1'b0, 32'hFFFF_FFFF);     // partial, stamp all ones
		send_idle(1'b1, 32'h0000_0000);     // forced discard keeps the stamp
		send_byte({1'b1, CH_STX});
		send_byte(8'h41);
		send_byte({1'b1, CH_ETX});
		send_byte(8'hAA);
		send_idle(1'b0, $urandom());        // shortest STX frame
		send_byte({1'b0, CH_STX});
		send_byte({1'b0, CH_ETX});
		send_byte(8'h7F);
		send_idle(1'b0, 32'h0000_0000);     // STX too short yet: partial
		send_byte(8'h10);
		send_idle(1'b0, $urandom());
		send_idle(1'b1, $urandom());        // forced discard on empty half
		send_read(1'b0, 9'd3);
		send_read(1'b1, 9'd0);
		send_byte({1'b1, CH_ACK});
		send_idle(1'b0, $urandom());
	endtask

	task automatic test_overflow_discard();
		logic h;
		h = shadow_half;
		if (shadow_fill != 0)
			send_idle(1'b1, $urandom());
		h = shadow_half;
		// fill the half and push a few more that must be dropped
		repeat (BUF_DEPTH + 3) send_byte(8'($urandom_range(255)));
		send_idle(1'b0, $urandom());
		send_read(h, 9'd511);
		send_read(h, 9'd256);
		send_read(h, 9'd255);
		send_read(h, 9'd0);
		repeat (4) send_read(h, 9'($urandom_range(BUF_DEPTH - 1)));
	endtask

	task automatic test_random_traffic(input int n);
		logic [7:0] b;
		int stop_at;
		int pick;
		int len;
		int cut;
		int i;
		stop_at = reqs_sent + n;
		while (reqs_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				// STX frame, mostly after a watchdog discard of leftovers
				if (shadow_fill != 0 && $urandom_range(3) != 0)
					send_idle(1'b1, $urandom());
				len = ($urandom_range(7) == 0) ? $urandom_range(17, 60)
					: $urandom_range(MIN_STX_LEN, 12);
				cut = ($urandom_range(2) == 0) ? $urandom_range(1, len - 1) : 0;
				for (i = 0; i < len; i++) begin
					b = 8'($urandom_range(255));
					if (i == 0)
						b = {b[7], CH_STX};
					else if (i == len - ETX_FROM_END)
						b = {b[7], CH_ETX};
					send_byte(b);
					if (i + 1 == cut)
						send_idle(1'b0, $urandom());
				end
				send_idle(1'b0, $urandom());
			end else if (pick < 55) begin
				if (shadow_fill != 0 && $urandom_range(3) != 0)
					send_idle(1'b1, $urandom());
				b = 8'($urandom_range(255));
				case ($urandom_range(2))
					0: b = {b[7], CH_ACK};
					1: b = {b[7], CH_NAK};
					default: b = {b[7], CH_ENQ};
				endcase
				send_byte(b);
				send_idle(1'b0, $urandom());
			end else if (pick < 72) begin
				repeat ($urandom_range(1, 3)) send_read_of_written();
			end else if (pick < 84) begin
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
				if ($urandom_range(1))
					send_idle(1'b0, $urandom());
			end else if (pick < 90) begin
				send_idle(1'b1, $urandom());
			end else if (pick < 95) begin
				send_idle(1'b0, $urandom());
			end else begin
				send_unused();
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.func <= FN_BYTE;
		cmd_ch.rx_byte <= '0;
		cmd_ch.force_reset <= 1'b0;
		cmd_ch.tick_value <= '0;
		cmd_ch.read_buffer <= 1'b0;
		cmd_ch.read_index <= '0;
		written_upto[0] = 0;
		written_upto[1] = 0;
		shadow_half = 1'b0;
		shadow_fill = 0;
		shadow_partial = 1'b0;
		shadow_stamp = '0;
		mismatches = 0;
		reqs_sent = 0;
		results_seen = 0;
		set_idling(0, 0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		set_idling(19, 19);
		test_overflow_discard();
		drain_results();
		set_idling(0, 0);
		test_random_traffic(225);
		set_idling(54, 0);
		test_random_traffic(225);
		// hold requests until the pipeline is empty, then resume
		drain_results();
		set_idling(0, 54);
		test_random_traffic(225);
		set_idling(19, 19);
		test_random_traffic(225);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ufdb_pkg.sv
sv/ufdb_if.sv
sv/ufdb_store.sv
sv/uart_frame_double_buffer_receiver_top.sv
sim/uart_frame_double_buffer_receiver_top_tb.sv
